FILE: design/quaternion_normal_alignment_cost_assert.svh
// assertion macros for the checker file
// each macro expects clk and rst to be visible where it is used
`ifndef QUATERNION_NORMAL_ALIGNMENT_COST_ASSERT_SVH
`define QUATERNION_NORMAL_ALIGNMENT_COST_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define QNAC_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("qnac assertion failed");

// consequent must hold in the cycle after the antecedent
`define QNAC_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("qnac assertion failed");

`endif

FILE: design/qnac_pkg.sv
package qnac_pkg;

  // field and register widths
  localparam int Q_W         = 16;
  localparam int FRAC_BITS   = 15;
  localparam int MAX_SAMPLES = 4096;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = 40;
  localparam int MEAN_W      = 24;
  localparam int CFG_IDX_W   = 8;
  localparam int IN_TDATA_W  = 6 * Q_W;
  localparam int OUT_TUSER_W = 2;

  // internal datapath widths
  localparam int MUL_W    = 21;
  localparam int MAT_W    = 35;
  localparam int RM_W     = 19;
  localparam int ACC_W    = 36;
  localparam int D_W      = 21;
  localparam int SQ_W     = 40;
  localparam int SQ_SHIFT = 2 * FRAC_BITS - 16;
  localparam int COST_W   = SQ_W - SQ_SHIFT;
  localparam int REM_W    = CNT_W - 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = CFG_IDX_W'(3);

  localparam logic signed [Q_W-1:0] QUAT_W_RESET = 16'sd32767;

  typedef logic signed [Q_W-1:0] q15_t;

endpackage

FILE: design/quaternion_normal_alignment_cost.sv
// Quaternion normal alignment cost.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the four
// quaternion components, index 0..3 for x, y, z, w; other indexes are ignored.
// cfg_ready is always high. Write only while the block is idle.
// Slave stream carries one lidar/camera normal pair per item, tuser is
// feature_valid and tlast marks the last sample of a set. The master stream
// gives one result per set: tdata is mean_cost, tuser is {saturated, empty_set}.
// One shared 21x21 multiplier does all products, so s_tready is high only when
// the sequencer is idle. A counted sample goes through accept, 9 rotation
// products, 3 squares, accumulate and finish; the first counted sample after
// a quaternion write first rebuilds the matrix from 9 products and a rounding
// step. An uncounted sample goes from accept straight to finish. On the last
// sample the 24-step restoring divider runs before the output register is
// loaded; an empty or saturated set skips the divider and is loaded directly.
// Reset clears the running sum and count, sets the quaternion to near unity
// and drops m_tvalid. A stalled result holds in the output register; the
// block keeps accepting items and waits only if another result is ready.
module quaternion_normal_alignment_cost (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qnac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qnac_pkg::Q_W-1:0]         cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // lidar_nx, lidar_ny, lidar_nz, cam_nx, cam_ny, cam_nz
  input  logic [qnac_pkg::IN_TDATA_W-1:0]  s_tdata,
  // feature_valid
  input  logic                             s_tuser,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // mean_cost
  output logic [qnac_pkg::MEAN_W-1:0]      m_tdata,
  // empty_set, saturated
  output logic [qnac_pkg::OUT_TUSER_W-1:0] m_tuser
);
  import qnac_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MAT  = 4'd1;
  localparam logic [3:0] ST_MATR = 4'd2;
  localparam logic [3:0] ST_ROT  = 4'd3;
  localparam logic [3:0] ST_SQ   = 4'd4;
  localparam logic [3:0] ST_ACC  = 4'd5;
  localparam logic [3:0] ST_FIN  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam int STEP_W = $clog2(MEAN_W);
  localparam logic [STEP_W-1:0] MAT_LAST = STEP_W'(8);
  localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(8);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(MEAN_W - 1);
  localparam logic [1:0]        COL_LAST = 2'd2;

  localparam logic signed [MAT_W-1:0] ONE2     = MAT_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [MAT_W-1:0] MAT_HALF = MAT_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ROT_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [SQ_W-1:0]         SQ_HALF  = SQ_W'(1) << (SQ_SHIFT - 1);
  localparam logic [SUM_W-1:0]        SUM_MAX  = '1;
  localparam logic [MEAN_W-1:0]       MEAN_MAX = '1;

  logic [3:0]        state;
  logic [STEP_W-1:0] step;
  logic [1:0]        row;
  logic [1:0]        col;
  q15_t              quat_x, quat_y, quat_z, quat_w;
  logic              dirty;
  q15_t              ln [3];
  q15_t              cn [3];
  logic              last_flag;
  logic signed [31:0]     p  [9];
  logic signed [RM_W-1:0] rm [9];
  logic signed [ACC_W-1:0] acc;
  logic signed [D_W-1:0]  dv [3];
  logic [SQ_W-1:0]   sq;
  logic [SUM_W-1:0]  cost_sum;
  logic [CNT_W-1:0]  valid_count;
  logic [REM_W-1:0]  rem;
  logic [MEAN_W-1:0] quo;
  logic              res_empty;
  logic              res_sat;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic signed [MAT_W-1:0]   mat_r2 [9];
  logic signed [ACC_W-1:0]   cn_ext, rot_base, rot_sum, rot_shift;
  logic [SQ_W-1:0]           sq_sum;
  logic [COST_W-1:0]         cost;
  logic [SUM_W:0]            acc_sum;
  logic [SUM_W:0]            div_dvd, div_lim;
  logic                      div_over;
  logic [CNT_W-1:0]          div_trial;
  logic                      div_ge;

  // round a doubled-precision matrix entry back to FRAC_BITS
  function automatic logic signed [RM_W-1:0] rm_round(input logic signed [MAT_W-1:0] r2);
    logic signed [MAT_W-1:0] t;
    t = r2 + MAT_HALF;
    return RM_W'(t >>> FRAC_BITS);
  endfunction

  function automatic logic signed [MUL_W-1:0] q_ext(input q15_t v);
    return MUL_W'(v);
  endfunction

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MAT: begin
        case (step[3:0])
          4'd0: begin mul_a = q_ext(quat_x); mul_b = q_ext(quat_x); end
          4'd1: begin mul_a = q_ext(quat_y); mul_b = q_ext(quat_y); end
          4'd2: begin mul_a = q_ext(quat_z); mul_b = q_ext(quat_z); end
          4'd3: begin mul_a = q_ext(quat_x); mul_b = q_ext(quat_y); end
          4'd4: begin mul_a = q_ext(quat_x); mul_b = q_ext(quat_z); end
          4'd5: begin mul_a = q_ext(quat_y); mul_b = q_ext(quat_z); end
          4'd6: begin mul_a = q_ext(quat_w); mul_b = q_ext(quat_x); end
          4'd7: begin mul_a = q_ext(quat_w); mul_b = q_ext(quat_y); end
          default: begin mul_a = q_ext(quat_w); mul_b = q_ext(quat_z); end
        endcase
      end
      ST_ROT: begin
        mul_a = MUL_W'(rm[step[3:0]]);
        mul_b = q_ext(ln[col]);
      end
      ST_SQ: begin
        mul_a = dv[col];
        mul_b = dv[col];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // rotation matrix at double precision from the stored products
  // p: xx yy zz xy xz yz wx wy wz
  always_comb begin
    mat_r2[0] = ONE2 - ((MAT_W'(p[1]) + MAT_W'(p[2])) <<< 1);
    mat_r2[1] = (MAT_W'(p[3]) - MAT_W'(p[8])) <<< 1;
    mat_r2[2] = (MAT_W'(p[4]) + MAT_W'(p[7])) <<< 1;
    mat_r2[3] = (MAT_W'(p[3]) + MAT_W'(p[8])) <<< 1;
    mat_r2[4] = ONE2 - ((MAT_W'(p[0]) + MAT_W'(p[2])) <<< 1);
    mat_r2[5] = (MAT_W'(p[5]) - MAT_W'(p[6])) <<< 1;
    mat_r2[6] = (MAT_W'(p[4]) - MAT_W'(p[7])) <<< 1;
    mat_r2[7] = (MAT_W'(p[5]) + MAT_W'(p[6])) <<< 1;
    mat_r2[8] = ONE2 - ((MAT_W'(p[0]) + MAT_W'(p[1])) <<< 1);
  end

  // row dot product, seeded with the camera term and the rounding half
  always_comb begin
    cn_ext    = ACC_W'(cn[row]);
    rot_base  = ROT_HALF - (cn_ext <<< FRAC_BITS);
    rot_sum   = ((col == 2'd0) ? rot_base : acc) + prod[ACC_W-1:0];
    rot_shift = rot_sum >>> FRAC_BITS;
  end

  // squares, seeded with the rounding half of the final shift
  assign sq_sum  = ((col == 2'd0) ? SQ_HALF : sq) + prod[SQ_W-1:0];
  assign cost    = sq[SQ_W-1:SQ_SHIFT];
  assign acc_sum = {1'b0, cost_sum} + (SUM_W + 1)'(cost);

  // mean division setup and one restoring step
  assign div_dvd   = {1'b0, cost_sum} + (SUM_W + 1)'(valid_count >> 1);
  assign div_lim   = (SUM_W + 1)'({valid_count, {MEAN_W{1'b0}}});
  assign div_over  = (div_dvd >= div_lim);
  assign div_trial = {rem, quo[MEAN_W-1]};
  assign div_ge    = (div_trial >= valid_count);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      row         <= '0;
      col         <= '0;
      quat_x      <= '0;
      quat_y      <= '0;
      quat_z      <= '0;
      quat_w      <= QUAT_W_RESET;
      dirty       <= 1'b1;
      cost_sum    <= '0;
      valid_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          REG_QUAT_X: begin quat_x <= cfg_data; dirty <= 1'b1; end
          REG_QUAT_Y: begin quat_y <= cfg_data; dirty <= 1'b1; end
          REG_QUAT_Z: begin quat_z <= cfg_data; dirty <= 1'b1; end
          REG_QUAT_W: begin quat_w <= cfg_data; dirty <= 1'b1; end
          default: ;
        endcase
      end

      // result taken, unless a new one is loaded in the same cycle
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            for (int k = 0; k < 3; k++) begin
              ln[k] <= s_tdata[k*Q_W +: Q_W];
              cn[k] <= s_tdata[(k+3)*Q_W +: Q_W];
            end
            last_flag <= s_tlast;
            step      <= '0;
            row       <= '0;
            col       <= '0;
            if (s_tuser && (valid_count < CNT_W'(MAX_SAMPLES))) begin
              state <= dirty ? ST_MAT : ST_ROT;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_MAT: begin
          p[step[3:0]] <= prod[31:0];
          if (step == MAT_LAST) begin
            step  <= '0;
            state <= ST_MATR;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_MATR: begin
          for (int k = 0; k < 9; k++) begin
            rm[k] <= rm_round(mat_r2[k]);
          end
          dirty <= 1'b0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          acc <= rot_sum;
          if (col == COL_LAST) begin
            dv[row] <= rot_shift[D_W-1:0];
          end
          if (step == ROT_LAST) begin
            step  <= '0;
            row   <= '0;
            col   <= '0;
            state <= ST_SQ;
          end else begin
            step <= step + 1'b1;
            if (col == COL_LAST) begin
              col <= '0;
              row <= row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        ST_SQ: begin
          sq <= sq_sum;
          if (col == COL_LAST) begin
            col   <= '0;
            state <= ST_ACC;
          end else begin
            col <= col + 1'b1;
          end
        end
        ST_ACC: begin
          cost_sum    <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
          valid_count <= valid_count + 1'b1;
          state       <= ST_FIN;
        end
        ST_FIN: begin
          res_empty <= (valid_count == '0);
          res_sat   <= (valid_count != '0) && ((cost_sum == SUM_MAX) || div_over);
          step      <= '0;
          if (!last_flag) begin
            state <= ST_IDLE;
          end else if (valid_count == '0) begin
            state <= ST_OUT;
          end else if (cost_sum == SUM_MAX || div_over) begin
            state <= ST_OUT;
          end else begin
            rem   <= div_dvd[MEAN_W +: REM_W];
            quo   <= div_dvd[MEAN_W-1:0];
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= div_ge ? REM_W'(div_trial - valid_count) : div_trial[REM_W-1:0];
          quo <= {quo[MEAN_W-2:0], div_ge};
          if (step == DIV_LAST) begin
            state <= ST_OUT;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            m_tdata     <= res_sat ? MEAN_MAX : (res_empty ? '0 : quo);
            m_tuser     <= {res_sat, res_empty};
            cost_sum    <= '0;
            valid_count <= '0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/qnac_checker.sv
`include "quaternion_normal_alignment_cost_assert.svh"

module qnac_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [qnac_pkg::MEAN_W-1:0]      m_tdata,
  input logic [qnac_pkg::OUT_TUSER_W-1:0] m_tuser
);

  // a stalled result holds its payload
  `QNAC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // an empty set reports zero and is never saturated
  `QNAC_ASSERT_SAME(a_empty_zero, m_tvalid && m_tuser[0], (m_tdata == '0) && !m_tuser[1])

  // a saturated mean sits at its ceiling
  `QNAC_ASSERT_SAME(a_sat_max, m_tvalid && m_tuser[1], &m_tdata)

  // the sequencer is busy in the cycle after an item is taken
  `QNAC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

bind quaternion_normal_alignment_cost qnac_checker u_checker (.*);
